// ----- rtl/lkvc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types for the LRU key/value cache
// Item and result structs, register address codes, controller commands.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int unsigned KeyBits   = 32;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned CapBits   = 5;

  localparam logic [1:0] AddrCapacity = 2'd0;
  localparam logic       ActLookup    = 1'b0;
  localparam logic       ActStore     = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
  } item_t;

  typedef struct packed {
    logic                 found;
    logic [ValueBits-1:0] value_out;
  } result_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } status_t;

endpackage

// ----- rtl/lru_key_value_cache_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_top: fully associative LRU key/value cache
//
//   channel  | signals                        | handshake
//   item     | start_i, item_i                | start_i && !busy_o
//   result   | done_o, result_o               | one-cycle strobe
//   config   | psel/penable/pwrite/paddr/...  | APB, pready high
//
// An item is loaded, then scanned one entry a cycle for hit, free slot and
// oldest entry, then committed; the result strobe is registered and comes in
// the cycle after commit, while the next item may start. Reset clears valid
// bits, ranks and count. The receiver cannot stall.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  lkvc_pkg::item_t      item_i,
  output logic                 busy_o,
  output logic                 done_o,
  output lkvc_pkg::result_t    result_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  lkvc_pkg::cmd_t    cmd;
  lkvc_pkg::status_t status;
  logic [lkvc_pkg::CapBits-1:0] cap_q;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CapBits'(16);
    end else if (psel && penable && pwrite && paddr == lkvc_pkg::AddrCapacity) begin
      cap_q <= pwdata[lkvc_pkg::CapBits-1:0];
    end
  end
  assign prdata = (paddr == lkvc_pkg::AddrCapacity) ? {27'd0, cap_q} : 32'd0;

  lkvc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  lkvc_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (lkvc_pkg::KeyBits),
    .VALUE_BITS (lkvc_pkg::ValueBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .action_i    (item_i.action),
    .key_i       (item_i.key),
    .value_i     (item_i.value),
    .cap_i       (cap_q),
    .status_o    (status),
    .found_o     (result_o.found),
    .value_out_o (result_o.value_out),
    .done_o      (done_o)
  );

endmodule

// ----- rtl/lkvc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_ctrl: item sequencer
// Steps one item through load, entry scan and commit.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  lkvc_pkg::status_t status_i,
  output lkvc_pkg::cmd_t   cmd_o,
  output logic             busy_o
);

  typedef enum logic [1:0] {StIdle, StScan, StCommit} state_e;
  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle:   if (start_i) state_q <= StScan;
        StScan:   if (status_i.scan_done) state_q <= StCommit;
        StCommit: state_q <= StIdle;
        default:  state_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    cmd_o.load   = (state_q == StIdle) && start_i;
    cmd_o.scan   = (state_q == StScan);
    cmd_o.commit = (state_q == StCommit);
  end

  assign busy_o = (state_q != StIdle);

endmodule

// ----- rtl/lkvc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_datapath: entry store, key compare and recency update
// Scans entries one a cycle for hit, free slot and oldest, then commits.
// ----------------------------------------------------------------------------
module lkvc_datapath #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lkvc_pkg::cmd_t         cmd_i,
  input  logic                   action_i,
  input  logic [KEY_BITS-1:0]    key_i,
  input  logic [VALUE_BITS-1:0]  value_i,
  input  logic [lkvc_pkg::CapBits-1:0] cap_i,
  output lkvc_pkg::status_t      status_o,
  output logic                   found_o,
  output logic [VALUE_BITS-1:0]  value_out_o,
  output logic                   done_o
);

  localparam int unsigned IdxBits = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntBits = $clog2(ENTRIES + 1);

  logic [KEY_BITS-1:0]   key_q [ENTRIES];
  logic [VALUE_BITS-1:0] val_q [ENTRIES];
  logic [IdxBits-1:0]    rank_q [ENTRIES];
  logic [ENTRIES-1:0]    valid_q;
  logic [CntBits-1:0]    count_q;

  logic                  act_q;
  logic [KEY_BITS-1:0]   ikey_q;
  logic [VALUE_BITS-1:0] ival_q;
  logic [IdxBits-1:0]    idx_q;
  logic                  hit_q, free_q, old_any_q;
  logic [IdxBits-1:0]    hit_idx_q, free_idx_q, old_idx_q, old_rank_q;

  logic [CntBits-1:0] cap_eff;
  always_comb begin
    if (cap_i == '0) cap_eff = CntBits'(1);
    else if (32'(cap_i) > ENTRIES) cap_eff = CntBits'(ENTRIES);
    else cap_eff = CntBits'(cap_i);
  end

  logic scan_last;
  assign scan_last = (32'(idx_q) == ENTRIES - 1);
  assign status_o.scan_done = cmd_i.scan && scan_last;

  logic cur_match;
  assign cur_match = valid_q[idx_q] && (key_q[idx_q] == ikey_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      ikey_q <= key_i;
      ival_q <= value_i;
      idx_q <= '0;
      hit_q <= 1'b0;
      free_q <= 1'b0;
      old_any_q <= 1'b0;
      hit_idx_q <= '0;
      free_idx_q <= '0;
      old_idx_q <= '0;
      old_rank_q <= '0;
    end else if (cmd_i.scan) begin
      if (!scan_last) idx_q <= idx_q + 1'b1;
      if (cur_match && !hit_q) begin
        hit_q <= 1'b1;
        hit_idx_q <= idx_q;
      end
      if (!valid_q[idx_q] && !free_q) begin
        free_q <= 1'b1;
        free_idx_q <= idx_q;
      end
      if (valid_q[idx_q] && (!old_any_q || rank_q[idx_q] >= old_rank_q)) begin
        old_any_q <= 1'b1;
        old_rank_q <= rank_q[idx_q];
        old_idx_q <= idx_q;
      end
    end
  end

  logic               use_free, write_kv, write_v, do_touch;
  logic [IdxBits-1:0] slot;
  logic [CntBits-1:0] age;
  always_comb begin
    use_free = !hit_q && act_q && (count_q < cap_eff) && free_q;
    write_kv = !hit_q && act_q;
    write_v  = hit_q && act_q;
    do_touch = hit_q || act_q;
    if (hit_q) begin
      slot = hit_idx_q;
      age  = CntBits'(rank_q[hit_idx_q]);
    end else if (use_free) begin
      slot = free_idx_q;
      age  = CntBits'(ENTRIES);
    end else begin
      slot = old_idx_q;
      age  = old_any_q ? CntBits'(old_rank_q) : count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
    end else if (cmd_i.commit && do_touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && IdxBits'(i) != slot && CntBits'(rank_q[i]) < age)
          rank_q[i] <= rank_q[i] + 1'b1;
      end
      rank_q[slot] <= '0;
      if (write_kv && !valid_q[slot]) begin
        valid_q[slot] <= 1'b1;
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (write_kv) key_q[slot] <= ikey_q;
      if (write_kv || write_v) val_q[slot] <= ival_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
      found_o <= 1'b0;
      value_out_o <= '0;
    end else begin
      done_o <= cmd_i.commit;
      found_o <= hit_q;
      value_out_o <= (hit_q && !act_q) ? val_q[hit_idx_q] : '0;
    end
  end

endmodule

// ----- tb/lru_key_value_cache_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_top_tb: self-checking bench for the LRU key/value cache
// A queue of items feeds a clocked driver with random gaps. A clocked monitor
// compares each result strobe against a behavioral LRU table model. The
// capacity register is rewritten between phases while the cache is idle.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top_tb;

  localparam int unsigned Slots = 16;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  lkvc_pkg::item_t   item_i;
  logic              busy_o;
  logic              done_o;
  lkvc_pkg::result_t result_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [1:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  lru_key_value_cache_top #(.ENTRIES(Slots)) DUT (.*);

  // cache model
  logic [lkvc_pkg::KeyBits-1:0]   mdl_key   [Slots];
  logic [lkvc_pkg::ValueBits-1:0] mdl_value [Slots];
  logic                           mdl_valid [Slots];
  int unsigned                    mdl_age   [Slots];
  int unsigned                    mdl_count;
  logic [lkvc_pkg::CapBits-1:0]   mdl_capacity;

  lkvc_pkg::item_t   pending_items[$];
  lkvc_pkg::result_t expected_results[$];
  int                errors;
  int                gap;
  int                key_pool;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic void refresh_entry(int s, int unsigned age);
    for (int i = 0; i < Slots; i++)
      if (mdl_valid[i] && i != s && mdl_age[i] < age) mdl_age[i]++;
    mdl_age[s] = 0;
  endfunction

  function automatic lkvc_pkg::result_t predict_lookup_store(lkvc_pkg::item_t it);
    lkvc_pkg::result_t r;
    int unsigned       cap;
    int                hit;
    int                slot;
    int unsigned       oldest;
    cap = (mdl_capacity == 0) ? 1 : (mdl_capacity > Slots ? Slots : mdl_capacity);
    hit = -1;
    slot = -1;
    r = '0;
    for (int i = 0; i < Slots; i++)
      if (hit < 0 && mdl_valid[i] && mdl_key[i] == it.key) hit = i;
    if (hit >= 0) begin
      r.found = 1'b1;
      if (it.action == lkvc_pkg::ActStore) mdl_value[hit] = it.value;
      else r.value_out = mdl_value[hit];
      refresh_entry(hit, mdl_age[hit]);
      return r;
    end
    if (it.action == lkvc_pkg::ActLookup) return r;
    if (mdl_count < cap)
      for (int i = 0; i < Slots; i++)
        if (slot < 0 && !mdl_valid[i]) slot = i;
    if (slot >= 0) begin
      for (int i = 0; i < Slots; i++)
        if (mdl_valid[i]) mdl_age[i]++;
      mdl_valid[slot] = 1'b1;
      mdl_age[slot] = 0;
      mdl_count++;
    end else begin
      oldest = 0;
      slot = 0;
      for (int i = 0; i < Slots; i++)
        if (mdl_valid[i] && mdl_age[i] >= oldest) begin
          oldest = mdl_age[i];
          slot = i;
        end
      if (!mdl_valid[slot]) begin
        mdl_valid[slot] = 1'b1;
        mdl_count++;
        oldest = mdl_count;
      end
      refresh_entry(slot, oldest);
    end
    mdl_key[slot] = it.key;
    mdl_value[slot] = it.value;
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      item_i  <= '0;
      gap     <= 0;
    end else if (start_i && !busy_o) begin
      expected_results.push_back(predict_lookup_store(item_i));
      if (pending_items.size() > 0 && $urandom_range(0, 3) == 0) begin
        item_i <= pending_items.pop_front();
      end else begin
        start_i <= 1'b0;
        gap     <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
      end
    end else if (!start_i) begin
      if (gap > 0) begin
        gap <= gap - 1;
      end else if (pending_items.size() > 0) begin
        start_i <= 1'b1;
        item_i  <= pending_items.pop_front();
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result found=%0d value_out=%h", result_o.found, result_o.value_out);
        errors++;
      end else begin
        lkvc_pkg::result_t e;
        e = expected_results.pop_front();
        if (result_o.found !== e.found) begin
          $error("found: expected %0d actual %0d", e.found, result_o.found);
          errors++;
        end
        if (result_o.value_out !== e.value_out) begin
          $error("value_out: expected %h actual %h", e.value_out, result_o.value_out);
          errors++;
        end
      end
    end
  end

  function automatic logic [lkvc_pkg::KeyBits-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return '1;
      2: return '0;
      default: begin
        return lkvc_pkg::KeyBits'($urandom_range(0, key_pool - 1)) ^ 32'hA5A5_0000;
      end
    endcase
  endfunction

  task automatic add_item(logic act, logic [lkvc_pkg::KeyBits-1:0] k,
                          logic [lkvc_pkg::ValueBits-1:0] v);
    lkvc_pkg::item_t it;
    it.action = act;
    it.key    = k;
    it.value  = v;
    pending_items.push_back(it);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || start_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (Slots + 8) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lkvc_pkg::AddrCapacity;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mdl_capacity = data[lkvc_pkg::CapBits-1:0];
    @(posedge clk_i);
  endtask

  task automatic run_phase(int n);
    for (int i = 0; i < n; i++)
      add_item(($urandom_range(0, 9) < 5) ? lkvc_pkg::ActStore : lkvc_pkg::ActLookup,
               pick_key(), $urandom());
    drain();
  endtask

  initial begin
    logic [31:0] caps[$];
    errors = 0;
    key_pool = 24;
    for (int i = 0; i < Slots; i++) begin
      mdl_valid[i] = 1'b0;
      mdl_age[i]   = 0;
      mdl_key[i]   = '0;
      mdl_value[i] = '0;
    end
    mdl_count = 0;
    mdl_capacity = 16;
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_item(lkvc_pkg::ActLookup, 32'h0000_0000, 32'hFFFF_FFFF);
    add_item(lkvc_pkg::ActStore,  32'h0000_0000, 32'hFFFF_FFFF);
    add_item(lkvc_pkg::ActStore,  32'hFFFF_FFFF, 32'h0000_0000);
    add_item(lkvc_pkg::ActLookup, 32'h0000_0000, 32'h1234_5678);
    add_item(lkvc_pkg::ActLookup, 32'hFFFF_FFFF, 32'h0);
    add_item(lkvc_pkg::ActStore,  32'h0000_0000, 32'hDEAD_BEEF);
    add_item(lkvc_pkg::ActLookup, 32'h0000_0000, 32'h0);
    for (int i = 0; i < 17; i++)
      add_item(lkvc_pkg::ActStore, 32'h100 + i, 32'h5555_0000 + i);
    add_item(lkvc_pkg::ActLookup, 32'h0000_0000, 32'h0);
    drain();

    caps = '{32'd1, 32'd0, 32'd31, 32'd2, 32'd16, 32'd5, 32'd17, 32'd3};
    foreach (caps[c]) begin
      write_capacity(caps[c]);
      key_pool = (c % 2 == 0) ? 8 : 32;
      run_phase(140);
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/lkvc_pkg.sv
rtl/lkvc_ctrl.sv
rtl/lkvc_datapath.sv
rtl/lru_key_value_cache_top.sv
tb/lru_key_value_cache_top_tb.sv
